// ===== hw/rtl/latency_stats_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// Latency statistics monitor assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LATENCY_STATS_MONITOR_ASSERT_SVH
`define LATENCY_STATS_MONITOR_ASSERT_SVH

// Property checked at every rising clk edge outside reset.
`define LSM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lsm assertion failed");

// Same, with a message of its own.
`define LSM_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg
// Types and constants shared by the latency statistics monitor modules.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int NUM_POINTS = 8;
    localparam int IDX_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    localparam int PT_W   = 3;
    localparam int TS_W   = 64;
    localparam int CNT_W  = 32;
    localparam int PROD_W = TS_W + CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // shift-add multiply over the count bits, restoring divide over the sum
    localparam int MUL_STEPS = CNT_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STOP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MEAN,
        ST_WRITE
    } lsm_state_t;

    typedef enum logic [2:0] {
        MU_IDLE,
        MU_MUL,
        MU_ADD,
        MU_DIV,
        MU_DONE
    } lsm_mu_phase_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] c;
    } lsm_mu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lsm_mu_rsp_t;

endpackage

// ===== hw/rtl/lsm_mean_unit.sv =====
// ----------------------------------------------------------------------------
// lsm_mean_unit
// Iterative mean update: floor((m*(c-1) + d) / c), one bit per cycle.
// ----------------------------------------------------------------------------
module lsm_mean_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsm_pkg::lsm_mu_req_t         req,
    input  logic [lsm_pkg::TS_W-1:0]     m,
    input  logic [lsm_pkg::TS_W-1:0]     d,
    output lsm_pkg::lsm_mu_rsp_t         rsp,
    output logic [lsm_pkg::TS_W-1:0]     q
);
    import lsm_pkg::*;

    lsm_mu_phase_t       phase_reg;
    lsm_mu_phase_t       phase_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   acc_next;
    logic [TS_W-1:0]     m_reg;
    logic [TS_W-1:0]     d_reg;
    logic [CNT_W-1:0]    c_reg;
    logic [CNT_W-1:0]    w_reg;
    logic [CNT_W-1:0]    w_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;

    logic [CNT_W:0]      trial;
    logic [CNT_W+1:0]    diff;
    logic                ge;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MU_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = MU_MUL;
                end
            end
            MU_MUL:
            begin
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    phase_next = MU_ADD;
                end
            end
            MU_ADD:
            begin
                phase_next = MU_DIV;
            end
            MU_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    phase_next = MU_DONE;
                end
            end
            MU_DONE:
            begin
                phase_next = MU_IDLE;
            end
            default:
            begin
                phase_next = MU_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rsp.busy = (phase_reg != MU_IDLE);
        rsp.done = (phase_reg == MU_DONE);
        q        = acc_reg[TS_W-1:0];
    end

    // restoring divide step: remainder stays below the divisor
    assign trial = {rem_reg, acc_reg[PROD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, c_reg};
    assign ge    = !diff[CNT_W+1];

    always_comb
    begin
        step_next = (phase_next != phase_reg) ? '0 : step_reg + STEP_W'(1);
        acc_next  = acc_reg;
        w_next    = w_reg;
        rem_next  = rem_reg;
        unique case (phase_reg)
            MU_IDLE:
            begin
                acc_next = '0;
                w_next   = req.c - CNT_W'(1);
                rem_next = '0;
            end
            MU_MUL:
            begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (w_reg[CNT_W-1] ? {{CNT_W{1'b0}}, m_reg} : '0);
                w_next   = {w_reg[CNT_W-2:0], 1'b0};
            end
            MU_ADD:
            begin
                acc_next = acc_reg + {{CNT_W{1'b0}}, d_reg};
            end
            MU_DIV:
            begin
                acc_next = {acc_reg[PROD_W-2:0], ge};
                rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            end
            MU_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MU_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg != MU_IDLE || req.start)
        begin
            acc_reg <= acc_next;
            w_reg   <= w_next;
            rem_reg <= rem_next;
        end
        if (phase_reg == MU_IDLE && req.start)
        begin
            m_reg <= m;
            d_reg <= d;
            c_reg <= req.c;
        end
    end

endmodule

// ===== hw/rtl/latency_stats_monitor.sv =====
// ----------------------------------------------------------------------------
// latency_stats_monitor
// Per-point start/stop timing with duration, running mean, min, max, count.
// ----------------------------------------------------------------------------
//  channel  signals                       direction  payload
//  input    in_valid / in_stall           in         op, point, timestamp
//  output   out_valid / out_stall         out        point_out, duration, mean,
//                                                    minimum, maximum, count
//
//  One item at a time; the next item can be taken in the cycle after the
//  result register loads. A start goes from ST_IDLE to ST_WRITE; a stop
//  out of range or onto an unset mean passes through ST_DIFF first; a stop
//  that updates the mean also waits in ST_MEAN on lsm_mean_unit (32
//  shift-add multiply steps, one add, 96 restoring divide steps, a done step).
//  rst_n clears all per-point statistics at once, asynchronously.
//  A result waits in the output register while out_stall is high; the next
//  item is taken meanwhile, but its result waits for that register.
// ----------------------------------------------------------------------------
`include "latency_stats_monitor_assert.svh"

module latency_stats_monitor
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [lsm_pkg::PT_W-1:0]     point,
    input  logic [lsm_pkg::TS_W-1:0]     timestamp,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lsm_pkg::PT_W-1:0]     point_out,
    output logic [lsm_pkg::TS_W-1:0]     duration,
    output logic [lsm_pkg::TS_W-1:0]     mean,
    output logic [lsm_pkg::TS_W-1:0]     minimum,
    output logic [lsm_pkg::TS_W-1:0]     maximum,
    output logic [lsm_pkg::CNT_W-1:0]    count
);
    import lsm_pkg::*;

    lsm_state_t          state_reg;
    lsm_state_t          state_next;

    logic                op_reg;
    logic [PT_W-1:0]     point_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [TS_W-1:0]     d_reg;

    logic [TS_W-1:0]     stamp_reg [NUM_POINTS];
    logic [CNT_W-1:0]    count_reg [NUM_POINTS];
    logic [TS_W-1:0]     last_reg  [NUM_POINTS];
    logic [TS_W-1:0]     mean_reg  [NUM_POINTS];
    logic [TS_W-1:0]     min_reg   [NUM_POINTS];
    logic [TS_W-1:0]     max_reg   [NUM_POINTS];

    logic                out_valid_reg;
    logic [PT_W-1:0]     point_out_reg;
    logic [TS_W-1:0]     duration_reg;
    logic [TS_W-1:0]     mean_out_reg;
    logic [TS_W-1:0]     minimum_reg;
    logic [TS_W-1:0]     maximum_reg;
    logic [CNT_W-1:0]    count_out_reg;

    logic                in_fire;
    logic                wr_en;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    logic [TS_W-1:0]     cur_stamp;
    logic [CNT_W-1:0]    cur_count;
    logic [TS_W-1:0]     cur_last;
    logic [TS_W-1:0]     cur_mean;
    logic [TS_W-1:0]     cur_min;
    logic [TS_W-1:0]     cur_max;
    logic [TS_W-1:0]     diff_val;

    logic [CNT_W-1:0]    new_count;
    logic [TS_W-1:0]     new_last;
    logic [TS_W-1:0]     new_mean;
    logic [TS_W-1:0]     new_min;
    logic [TS_W-1:0]     new_max;

    lsm_mu_req_t         mu_req;
    lsm_mu_rsp_t         mu_rsp;
    logic [TS_W-1:0]     mu_q;

    assign in_fire  = in_valid && !in_stall;
    assign in_range = ({{(32-PT_W){1'b0}}, point_reg} < 32'(NUM_POINTS));
    assign idx      = IDX_W'(point_reg);

    assign cur_stamp = stamp_reg[idx];
    assign cur_count = count_reg[idx];
    assign cur_last  = last_reg[idx];
    assign cur_mean  = mean_reg[idx];
    assign cur_min   = min_reg[idx];
    assign cur_max   = max_reg[idx];
    assign diff_val  = ts_reg - cur_stamp;

    lsm_mean_unit u_mean
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mu_req),
        .m     (cur_mean),
        .d     (diff_val),
        .rsp   (mu_rsp),
        .q     (mu_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (op == OP_STOP) ? ST_DIFF : ST_WRITE;
                end
            end
            ST_DIFF:
            begin
                // out of range, or mean unset: nothing to divide
                state_next = (in_range && cur_mean != '0) ? ST_MEAN : ST_WRITE;
            end
            ST_MEAN:
            begin
                if (mu_rsp.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        mu_req.start = (state_reg == ST_DIFF) && in_range && (cur_mean != '0);
        mu_req.c     = (cur_count == '0) ? CNT_W'(1) : cur_count;
        wr_en        = (state_reg == ST_WRITE) && !(out_valid_reg && out_stall);
    end

    // updated entry
    always_comb
    begin
        new_count = cur_count;
        new_last  = cur_last;
        new_mean  = cur_mean;
        new_min   = cur_min;
        new_max   = cur_max;
        if (op_reg == OP_START)
        begin
            if (cur_count != CNT_MAX)
            begin
                new_count = cur_count + CNT_W'(1);
            end
        end
        else
        begin
            new_last = d_reg;
            new_mean = (cur_mean == '0) ? d_reg : mu_q;
            // zero minimum means unset
            if (cur_min == '0 || d_reg < cur_min)
            begin
                new_min = d_reg;
            end
            if (d_reg > cur_max)
            begin
                new_max = d_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                stamp_reg[i] <= '0;
                count_reg[i] <= '0;
                last_reg[i]  <= '0;
                mean_reg[i]  <= '0;
                min_reg[i]   <= '0;
                max_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en && in_range)
            begin
                if (op_reg == OP_START)
                begin
                    stamp_reg[idx] <= ts_reg;
                end
                count_reg[idx] <= new_count;
                last_reg[idx]  <= new_last;
                mean_reg[idx]  <= new_mean;
                min_reg[idx]   <= new_min;
                max_reg[idx]   <= new_max;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= op;
            point_reg <= point;
            ts_reg    <= timestamp;
        end
        if (state_reg == ST_DIFF)
        begin
            d_reg <= diff_val;
        end
        if (wr_en)
        begin
            point_out_reg <= point_reg;
            duration_reg  <= in_range ? new_last  : '0;
            mean_out_reg  <= in_range ? new_mean  : '0;
            minimum_reg   <= in_range ? new_min   : '0;
            maximum_reg   <= in_range ? new_max   : '0;
            count_out_reg <= in_range ? new_count : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_out = point_out_reg;
    assign duration  = duration_reg;
    assign mean      = mean_out_reg;
    assign minimum   = minimum_reg;
    assign maximum   = maximum_reg;
    assign count     = count_out_reg;

    `LSM_ASSERT(a_mu_done_in_mean, mu_rsp.done |-> (state_reg == ST_MEAN))
    `LSM_ASSERT(a_out_from_write, $rose(out_valid_reg) |-> ($past(state_reg) == ST_WRITE))
    `LSM_ASSERT_MSG(a_min_le_max, out_valid_reg |-> (minimum_reg <= maximum_reg), "min above max")
    `LSM_ASSERT(a_mu_idle_outside, (state_reg == ST_IDLE) |-> !mu_rsp.busy)

endmodule
